// ===== hw/rtl/ccre_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ccre_pkg
// Types, constants, saturating helpers and the per-axis operation sequence
// of the catmull-rom segment evaluator.
// ----------------------------------------------------------------------------
package ccre_pkg;

    localparam int COORD_BITS  = 48;
    localparam int WORD_BITS   = 64;
    localparam int T_BITS      = 17;
    localparam int ALPHA_BITS  = 17;
    localparam int LOG_BITS    = 24;
    localparam int MANT_BITS   = 31;
    localparam int IN_FIELDS_W = 3 * COORD_BITS + T_BITS;
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((3 * COORD_BITS + 7) / 8) * 8;
    localparam int MUL_STEPS   = WORD_BITS;
    localparam int DIV_STEPS   = WORD_BITS + 16;
    localparam int WIN_DEPTH   = 12;

    localparam logic [ALPHA_BITS-1:0] ALPHA_RESET = ALPHA_BITS'(32768);

    typedef logic signed [WORD_BITS-1:0]  word_t;
    typedef logic signed [COORD_BITS-1:0] coord_t;

    localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam word_t ONE_Q16  = word_t'(65536);

    // operation codes
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    // operand and destination codes
    localparam logic [4:0] R_P0  = 5'd0;
    localparam logic [4:0] R_P1  = 5'd1;
    localparam logic [4:0] R_P2  = 5'd2;
    localparam logic [4:0] R_P3  = 5'd3;
    localparam logic [4:0] R_T01 = 5'd4;
    localparam logic [4:0] R_T12 = 5'd5;
    localparam logic [4:0] R_T23 = 5'd6;
    localparam logic [4:0] R_S02 = 5'd7;
    localparam logic [4:0] R_S13 = 5'd8;
    localparam logic [4:0] R_D21 = 5'd9;
    localparam logic [4:0] R_M01 = 5'd10;
    localparam logic [4:0] R_M23 = 5'd11;
    localparam logic [4:0] R_M02 = 5'd12;
    localparam logic [4:0] R_M13 = 5'd13;
    localparam logic [4:0] R_M1  = 5'd14;
    localparam logic [4:0] R_M2  = 5'd15;
    localparam logic [4:0] R_A   = 5'd16;
    localparam logic [4:0] R_B   = 5'd17;
    localparam logic [4:0] R_R   = 5'd18;
    localparam logic [4:0] R_X   = 5'd19;
    localparam logic [4:0] R_T   = 5'd20;

    localparam logic [4:0] LAST_STEP = 5'd30;

    typedef struct packed {
        logic [1:0] op;
        logic [4:0] dst;
        logic [4:0] sa;
        logic [4:0] sb;
    } uop_t;

    function automatic word_t sat_add(word_t a, word_t b);
        logic signed [WORD_BITS:0] s;
        s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
        if (s[WORD_BITS] != s[WORD_BITS-1])
        begin
            return s[WORD_BITS] ? WORD_MIN : WORD_MAX;
        end
        return s[WORD_BITS-1:0];
    endfunction

    function automatic word_t sat_sub(word_t a, word_t b);
        logic signed [WORD_BITS:0] s;
        s = {a[WORD_BITS-1], a} - {b[WORD_BITS-1], b};
        if (s[WORD_BITS] != s[WORD_BITS-1])
        begin
            return s[WORD_BITS] ? WORD_MIN : WORD_MAX;
        end
        return s[WORD_BITS-1:0];
    endfunction

    function automatic logic [WORD_BITS-1:0] mag64(word_t a);
        return a[WORD_BITS-1] ? (~a + WORD_BITS'(1)) : a;
    endfunction

    function automatic word_t sat_signed(logic neg, logic ovf, logic [WORD_BITS-2:0] m);
        word_t v;
        v = {1'b0, m};
        if (ovf)
        begin
            return neg ? WORD_MIN : WORD_MAX;
        end
        return neg ? -v : v;
    endfunction

    function automatic word_t extend(coord_t c);
        return WORD_BITS'(c);
    endfunction

    function automatic coord_t to_coord(word_t v);
        word_t hi;
        word_t lo;
        hi = extend({1'b0, {(COORD_BITS-1){1'b1}}});
        lo = extend({1'b1, {(COORD_BITS-1){1'b0}}});
        if (v > hi)
        begin
            return hi[COORD_BITS-1:0];
        end
        if (v < lo)
        begin
            return lo[COORD_BITS-1:0];
        end
        return v[COORD_BITS-1:0];
    endfunction

    function automatic uop_t uop_at(logic [4:0] step);
        uop_t u;
        case (step)
            5'd0:    u = '{OP_ADD, R_S02, R_T01, R_T12};
            5'd1:    u = '{OP_ADD, R_S13, R_T12, R_T23};
            5'd2:    u = '{OP_SUB, R_D21, R_P2,  R_P1};
            5'd3:    u = '{OP_SUB, R_X,   R_P1,  R_P0};
            5'd4:    u = '{OP_DIV, R_M01, R_X,   R_T01};
            5'd5:    u = '{OP_SUB, R_X,   R_P3,  R_P2};
            5'd6:    u = '{OP_DIV, R_M23, R_X,   R_T23};
            5'd7:    u = '{OP_SUB, R_X,   R_P2,  R_P0};
            5'd8:    u = '{OP_DIV, R_M02, R_X,   R_S02};
            5'd9:    u = '{OP_SUB, R_X,   R_P3,  R_P1};
            5'd10:   u = '{OP_DIV, R_M13, R_X,   R_S13};
            5'd11:   u = '{OP_SUB, R_X,   R_M01, R_M02};
            5'd12:   u = '{OP_MUL, R_X,   R_T12, R_X};
            5'd13:   u = '{OP_ADD, R_M1,  R_D21, R_X};
            5'd14:   u = '{OP_SUB, R_X,   R_M23, R_M13};
            5'd15:   u = '{OP_MUL, R_X,   R_T12, R_X};
            5'd16:   u = '{OP_ADD, R_M2,  R_D21, R_X};
            5'd17:   u = '{OP_ADD, R_A,   R_M1,  R_M2};
            5'd18:   u = '{OP_SUB, R_A,   R_A,   R_D21};
            5'd19:   u = '{OP_SUB, R_A,   R_A,   R_D21};
            5'd20:   u = '{OP_ADD, R_B,   R_D21, R_D21};
            5'd21:   u = '{OP_ADD, R_B,   R_B,   R_D21};
            5'd22:   u = '{OP_SUB, R_B,   R_B,   R_M1};
            5'd23:   u = '{OP_SUB, R_B,   R_B,   R_M1};
            5'd24:   u = '{OP_SUB, R_B,   R_B,   R_M2};
            5'd25:   u = '{OP_MUL, R_R,   R_A,   R_T};
            5'd26:   u = '{OP_ADD, R_R,   R_R,   R_B};
            5'd27:   u = '{OP_MUL, R_R,   R_R,   R_T};
            5'd28:   u = '{OP_ADD, R_R,   R_R,   R_M1};
            5'd29:   u = '{OP_MUL, R_R,   R_R,   R_T};
            5'd30:   u = '{OP_ADD, R_R,   R_R,   R_P1};
            default: u = '{OP_ADD, R_X,   R_X,   R_X};
        endcase
        return u;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/centripetal_catmull_rom_eval_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// centripetal_catmull_rom_eval_unit
// Shift-in control point window and fixed-point catmull-rom segment
// evaluation with knot exponent alpha, built on bit-serial units.
// ----------------------------------------------------------------------------
// A load request (tuser 0) shifts one point into the four-point window. An
// evaluate request (tuser 1) returns one point; while it is being worked
// out no request is taken. Each of the three knots runs the 24-step log
// fraction loop once per mantissa bit (30 bits) on a single 31-bit squarer;
// the per-axis blend then runs four 80-step bit-serial divides and five
// 64-step bit-serial multiplies. Write the alpha register on the cfg channel
// only between requests; the block itself does not enforce this. Results are
// held in an output register until taken.
module centripetal_catmull_rom_eval_unit (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [ccre_pkg::ALPHA_BITS-1:0]     cfg_data,     // alpha
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [ccre_pkg::IN_TDATA_W-1:0]     s_tdata,      // point_x, point_y, point_z, param_t
    input  wire logic                                s_tuser,      // req_type
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [ccre_pkg::OUT_TDATA_W-1:0]         m_tdata       // curve_x, curve_y, curve_z
);
    import ccre_pkg::*;

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_K_DIFF   = 4'd1;
    localparam logic [3:0] ST_K_SCALE  = 4'd2;
    localparam logic [3:0] ST_K_SQ     = 4'd3;
    localparam logic [3:0] ST_K_CHECK  = 4'd4;
    localparam logic [3:0] ST_K_NORM   = 4'd5;
    localparam logic [3:0] ST_K_LOG    = 4'd6;
    localparam logic [3:0] ST_K_E      = 4'd7;
    localparam logic [3:0] ST_K_EXP    = 4'd8;
    localparam logic [3:0] ST_K_SHIFT  = 4'd9;
    localparam logic [3:0] ST_EV_ISSUE = 4'd10;
    localparam logic [3:0] ST_EV_MUL   = 4'd11;
    localparam logic [3:0] ST_EV_DIV   = 4'd12;
    localparam logic [3:0] ST_EV_WB    = 4'd13;
    localparam logic [3:0] ST_DONE     = 4'd14;

    localparam logic [33:0] LG_OFFSET = 34'd32 << LOG_BITS;

    // control state
    logic [3:0]            state_reg;
    logic [ALPHA_BITS-1:0] alpha_reg;
    logic                  m_tvalid_reg;
    logic [1:0]            kidx_reg;
    logic [1:0]            axis_reg;
    logic [4:0]            step_reg;
    logic [6:0]            ucnt_reg;
    logic [4:0]            lcnt_reg;
    logic [1:0]            sqcnt_reg;
    coord_t                win_reg [WIN_DEPTH];

    // datapath
    logic [T_BITS-1:0]     t_reg;
    logic [WORD_BITS-1:0]  kmag_reg [3];
    logic [5:0]            s_reg;
    logic [WORD_BITS-1:0]  sum_reg;
    logic [5:0]            p_reg;
    logic [MANT_BITS-1:0]  lm_reg;
    logic [LOG_BITS-1:0]   lf_reg;
    logic signed [33:0]    e_reg;
    logic [MANT_BITS-1:0]  mant_reg;
    logic [4:0]            bidx_reg;
    word_t t01_reg, t12_reg, t23_reg, s02_reg, s13_reg, d21_reg;
    word_t m01_reg, m23_reg, m02_reg, m13_reg, m1_reg, m2_reg;
    word_t a_reg, b_reg, r_reg, x_reg;
    logic [WORD_BITS-1:0]  mul_a_reg;
    logic [WORD_BITS-1:0]  mul_hi_reg;
    logic [WORD_BITS-1:0]  mul_lo_reg;
    logic                  mul_neg_reg;
    logic [DIV_STEPS-1:0]  div_num_reg;
    logic [DIV_STEPS-1:0]  div_q_reg;
    logic [WORD_BITS-1:0]  div_rem_reg;
    logic [WORD_BITS-1:0]  div_den_reg;
    logic                  div_neg_reg;
    coord_t                res_reg [3];
    logic [OUT_TDATA_W-1:0] out_data_reg;

    logic s_accept;
    assign s_accept  = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = out_data_reg;

    // knot pair selection
    coord_t ka [3];
    coord_t kb [3];
    logic [WORD_BITS-1:0] kd_mag [3];

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            case (kidx_reg)
                2'd0:
                begin
                    ka[j] = win_reg[j];
                    kb[j] = win_reg[3 + j];
                end
                2'd1:
                begin
                    ka[j] = win_reg[3 + j];
                    kb[j] = win_reg[6 + j];
                end
                default:
                begin
                    ka[j] = win_reg[6 + j];
                    kb[j] = win_reg[9 + j];
                end
            endcase
            kd_mag[j] = mag64(sat_sub(extend(kb[j]), extend(ka[j])));
        end
    end

    logic kbig;
    assign kbig = (|kmag_reg[0][WORD_BITS-1:31]) || (|kmag_reg[1][WORD_BITS-1:31])
               || (|kmag_reg[2][WORD_BITS-1:31]);

    // shared squarer and log-fraction step
    logic [MANT_BITS-1:0]   sq_in;
    logic [2*MANT_BITS-1:0] sq_out;
    logic [MANT_BITS:0]     sq_sh;
    logic                   lbit;
    logic [MANT_BITS-1:0]   lm_step;
    logic [LOG_BITS-1:0]    lf_step;

    assign sq_in   = (state_reg == ST_K_SQ) ? kmag_reg[0][MANT_BITS-1:0] : lm_reg;
    assign sq_out  = sq_in * sq_in;
    assign sq_sh   = sq_out[2*MANT_BITS-1:MANT_BITS-1];
    assign lbit    = sq_sh[MANT_BITS];
    assign lm_step = lbit ? sq_sh[MANT_BITS:1] : sq_sh[MANT_BITS-1:0];
    assign lf_step = {lf_reg[LOG_BITS-2:0], lbit};

    logic [MANT_BITS-1:0] cand;
    logic [MANT_BITS-1:0] mant_keep;
    logic [MANT_BITS-1:0] cand_after;
    logic [4:0]           bidx_dec;
    assign cand       = mant_reg | (MANT_BITS'(1) << bidx_reg);
    assign mant_keep  = (lf_step <= e_reg[LOG_BITS-1:0]) ? cand : mant_reg;
    assign bidx_dec   = bidx_reg - 5'd1;
    assign cand_after = mant_keep | (MANT_BITS'(1) << bidx_dec);

    // exponent of the knot
    logic [7:0]         ps;
    logic signed [33:0] lg;
    logic signed [51:0] e_prod;
    assign ps     = 8'(p_reg) + {1'b0, s_reg, 1'b0};
    assign lg     = $signed({2'b00, ps, lf_reg} - LG_OFFSET);
    assign e_prod = $signed({1'b0, alpha_reg}) * lg;

    // knot value from mantissa and exponent
    logic signed [9:0]  e_int;
    logic signed [10:0] sh;
    logic [10:0]        nsh;
    word_t              knot_val;
    assign e_int = e_reg[33:24];
    assign sh    = {e_int[9], e_int} - 11'sd14;
    assign nsh   = 11'(-sh);

    always_comb
    begin
        if (state_reg == ST_K_CHECK)
        begin
            knot_val = (alpha_reg == '0) ? ONE_Q16 : '0;
        end
        else if (sh > 11'sd32)
        begin
            knot_val = WORD_MAX;
        end
        else if (!sh[10])
        begin
            knot_val = {33'd0, mant_reg} << sh[5:0];
        end
        else if (sh <= -11'sd63)
        begin
            knot_val = '0;
        end
        else
        begin
            knot_val = {33'd0, mant_reg} >> nsh[5:0];
        end
    end

    logic knot_store;
    assign knot_store = ((state_reg == ST_K_CHECK) && (sum_reg == '0))
                     || (state_reg == ST_K_SHIFT);

    // operation sequence and operand selection
    uop_t  uop;
    word_t p_ax [4];
    word_t opa, opb, alu_res;
    assign uop = uop_at(step_reg);

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            case (axis_reg)
                2'd0:    p_ax[k] = extend(win_reg[3 * k]);
                2'd1:    p_ax[k] = extend(win_reg[3 * k + 1]);
                default: p_ax[k] = extend(win_reg[3 * k + 2]);
            endcase
        end
    end

    function automatic word_t pick(logic [4:0] sel, word_t p0, word_t p1, word_t p2,
                                   word_t p3, word_t t01, word_t t12, word_t t23,
                                   word_t s02, word_t s13, word_t d21, word_t m01,
                                   word_t m23, word_t m02, word_t m13, word_t m1,
                                   word_t m2, word_t a, word_t b, word_t r, word_t x,
                                   word_t t);
        case (sel)
            R_P0:    return p0;
            R_P1:    return p1;
            R_P2:    return p2;
            R_P3:    return p3;
            R_T01:   return t01;
            R_T12:   return t12;
            R_T23:   return t23;
            R_S02:   return s02;
            R_S13:   return s13;
            R_D21:   return d21;
            R_M01:   return m01;
            R_M23:   return m23;
            R_M02:   return m02;
            R_M13:   return m13;
            R_M1:    return m1;
            R_M2:    return m2;
            R_A:     return a;
            R_B:     return b;
            R_R:     return r;
            R_X:     return x;
            R_T:     return t;
            default: return '0;
        endcase
    endfunction

    word_t t_word;
    assign t_word = {{(WORD_BITS-T_BITS){1'b0}}, t_reg};

    assign opa = pick(uop.sa, p_ax[0], p_ax[1], p_ax[2], p_ax[3], t01_reg, t12_reg, t23_reg,
                      s02_reg, s13_reg, d21_reg, m01_reg, m23_reg, m02_reg, m13_reg,
                      m1_reg, m2_reg, a_reg, b_reg, r_reg, x_reg, t_word);
    assign opb = pick(uop.sb, p_ax[0], p_ax[1], p_ax[2], p_ax[3], t01_reg, t12_reg, t23_reg,
                      s02_reg, s13_reg, d21_reg, m01_reg, m23_reg, m02_reg, m13_reg,
                      m1_reg, m2_reg, a_reg, b_reg, r_reg, x_reg, t_word);
    assign alu_res = (uop.op == OP_SUB) ? sat_sub(opa, opb) : sat_add(opa, opb);

    // bit-serial multiply step
    logic [WORD_BITS:0] mul_sum;
    word_t              mul_res;
    assign mul_sum = {1'b0, mul_hi_reg} + {1'b0, (mul_lo_reg[0] ? mul_a_reg : '0)};
    assign mul_res = sat_signed(mul_neg_reg, |mul_hi_reg[WORD_BITS-1:15],
                                {mul_hi_reg[14:0], mul_lo_reg[WORD_BITS-1:16]});

    // bit-serial restoring divide step
    logic [WORD_BITS:0] div_r2;
    logic               div_ge;
    logic [WORD_BITS:0] div_diff;
    word_t              div_res;
    assign div_r2   = {div_rem_reg, div_num_reg[DIV_STEPS-1]};
    assign div_ge   = div_r2 >= {1'b0, div_den_reg};
    assign div_diff = div_r2 - {1'b0, div_den_reg};
    assign div_res  = sat_signed(div_neg_reg, |div_q_reg[DIV_STEPS-1:WORD_BITS-1],
                                 div_q_reg[WORD_BITS-2:0]);

    logic div_skip;
    assign div_skip = (opb <= word_t'(1));

    // register write port
    logic  wr_en;
    word_t wr_val;
    always_comb
    begin
        wr_en  = 1'b0;
        wr_val = alu_res;
        if (state_reg == ST_EV_ISSUE)
        begin
            if (uop.op == OP_ADD || uop.op == OP_SUB)
            begin
                wr_en = 1'b1;
            end
            else if (uop.op == OP_DIV && div_skip)
            begin
                wr_en  = 1'b1;
                wr_val = '0;
            end
        end
        else if (state_reg == ST_EV_WB)
        begin
            wr_en  = 1'b1;
            wr_val = (uop.op == OP_MUL) ? mul_res : div_res;
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            alpha_reg    <= ALPHA_RESET;
            m_tvalid_reg <= 1'b0;
            kidx_reg     <= '0;
            axis_reg     <= '0;
            step_reg     <= '0;
            ucnt_reg     <= '0;
            lcnt_reg     <= '0;
            sqcnt_reg    <= '0;
            for (int i = 0; i < WIN_DEPTH; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                alpha_reg <= cfg_data;
            end
            if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (s_accept)
                    begin
                        if (!s_tuser)
                        begin
                            for (int i = 0; i < WIN_DEPTH - 3; i++)
                            begin
                                win_reg[i] <= win_reg[i + 3];
                            end
                            for (int j = 0; j < 3; j++)
                            begin
                                win_reg[WIN_DEPTH - 3 + j] <=
                                    s_tdata[j*COORD_BITS +: COORD_BITS];
                            end
                        end
                        else
                        begin
                            kidx_reg  <= '0;
                            state_reg <= ST_K_DIFF;
                        end
                    end
                end
                ST_K_DIFF:
                begin
                    state_reg <= ST_K_SCALE;
                end
                ST_K_SCALE:
                begin
                    if (!kbig)
                    begin
                        sqcnt_reg <= '0;
                        state_reg <= ST_K_SQ;
                    end
                end
                ST_K_SQ:
                begin
                    sqcnt_reg <= sqcnt_reg + 2'd1;
                    if (sqcnt_reg == 2'd2)
                    begin
                        state_reg <= ST_K_CHECK;
                    end
                end
                ST_K_CHECK:
                begin
                    if (sum_reg != '0)
                    begin
                        state_reg <= ST_K_NORM;
                    end
                end
                ST_K_NORM:
                begin
                    if (sum_reg[WORD_BITS-1])
                    begin
                        lcnt_reg  <= '0;
                        state_reg <= ST_K_LOG;
                    end
                end
                ST_K_LOG:
                begin
                    lcnt_reg <= lcnt_reg + 5'd1;
                    if (lcnt_reg == 5'(LOG_BITS - 1))
                    begin
                        state_reg <= ST_K_E;
                    end
                end
                ST_K_E:
                begin
                    lcnt_reg  <= '0;
                    state_reg <= ST_K_EXP;
                end
                ST_K_EXP:
                begin
                    if (lcnt_reg == 5'(LOG_BITS - 1))
                    begin
                        lcnt_reg <= '0;
                        if (bidx_reg == '0)
                        begin
                            state_reg <= ST_K_SHIFT;
                        end
                    end
                    else
                    begin
                        lcnt_reg <= lcnt_reg + 5'd1;
                    end
                end
                ST_K_SHIFT:
                begin
                    state_reg <= ST_K_DIFF;
                end
                ST_EV_ISSUE:
                begin
                    ucnt_reg <= '0;
                    if (uop.op == OP_MUL)
                    begin
                        state_reg <= ST_EV_MUL;
                    end
                    else if (uop.op == OP_DIV && !div_skip)
                    begin
                        state_reg <= ST_EV_DIV;
                    end
                    else if (step_reg == LAST_STEP)
                    begin
                        step_reg <= '0;
                        if (axis_reg == 2'd2)
                        begin
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            axis_reg <= axis_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        step_reg <= step_reg + 5'd1;
                    end
                end
                ST_EV_MUL:
                begin
                    ucnt_reg <= ucnt_reg + 7'd1;
                    if (ucnt_reg == 7'(MUL_STEPS - 1))
                    begin
                        state_reg <= ST_EV_WB;
                    end
                end
                ST_EV_DIV:
                begin
                    ucnt_reg <= ucnt_reg + 7'd1;
                    if (ucnt_reg == 7'(DIV_STEPS - 1))
                    begin
                        state_reg <= ST_EV_WB;
                    end
                end
                ST_EV_WB:
                begin
                    step_reg  <= step_reg + 5'd1;
                    state_reg <= ST_EV_ISSUE;
                end
                ST_DONE:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
            if (knot_store)
            begin
                if (kidx_reg == 2'd2)
                begin
                    axis_reg  <= '0;
                    step_reg  <= '0;
                    state_reg <= ST_EV_ISSUE;
                end
                else
                begin
                    kidx_reg  <= kidx_reg + 2'd1;
                    state_reg <= ST_K_DIFF;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (s_accept && s_tuser)
                begin
                    t_reg <= s_tdata[3*COORD_BITS +: T_BITS];
                end
            end
            ST_K_DIFF:
            begin
                for (int j = 0; j < 3; j++)
                begin
                    kmag_reg[j] <= kd_mag[j];
                end
                s_reg   <= '0;
                sum_reg <= '0;
            end
            ST_K_SCALE:
            begin
                if (kbig)
                begin
                    for (int j = 0; j < 3; j++)
                    begin
                        kmag_reg[j] <= kmag_reg[j] >> 1;
                    end
                    s_reg <= s_reg + 6'd1;
                end
            end
            ST_K_SQ:
            begin
                sum_reg     <= sum_reg + {2'b00, sq_out};
                kmag_reg[0] <= kmag_reg[1];
                kmag_reg[1] <= kmag_reg[2];
            end
            ST_K_CHECK:
            begin
                p_reg <= 6'd63;
            end
            ST_K_NORM:
            begin
                if (!sum_reg[WORD_BITS-1])
                begin
                    sum_reg <= sum_reg << 1;
                    p_reg   <= p_reg - 6'd1;
                end
                else
                begin
                    lm_reg <= sum_reg[WORD_BITS-1 -: MANT_BITS];
                    lf_reg <= '0;
                end
            end
            ST_K_LOG:
            begin
                lm_reg <= lm_step;
                lf_reg <= lf_step;
            end
            ST_K_E:
            begin
                e_reg    <= e_prod[50:17];
                mant_reg <= MANT_BITS'(1) << (MANT_BITS - 1);
                bidx_reg <= 5'(MANT_BITS - 2);
                lm_reg   <= (MANT_BITS'(1) << (MANT_BITS - 1))
                          | (MANT_BITS'(1) << (MANT_BITS - 2));
                lf_reg   <= '0;
            end
            ST_K_EXP:
            begin
                if (lcnt_reg == 5'(LOG_BITS - 1))
                begin
                    mant_reg <= mant_keep;
                    bidx_reg <= bidx_dec;
                    lm_reg   <= cand_after;
                    lf_reg   <= '0;
                end
                else
                begin
                    lm_reg <= lm_step;
                    lf_reg <= lf_step;
                end
            end
            ST_EV_ISSUE:
            begin
                mul_a_reg   <= mag64(opa);
                mul_lo_reg  <= mag64(opb);
                mul_hi_reg  <= '0;
                mul_neg_reg <= opa[WORD_BITS-1] ^ opb[WORD_BITS-1];
                div_num_reg <= {mag64(opa), 16'd0};
                div_den_reg <= opb;
                div_rem_reg <= '0;
                div_q_reg   <= '0;
                div_neg_reg <= opa[WORD_BITS-1];
                if (step_reg == LAST_STEP)
                begin
                    case (axis_reg)
                        2'd0:    res_reg[0] <= to_coord(alu_res);
                        2'd1:    res_reg[1] <= to_coord(alu_res);
                        default: res_reg[2] <= to_coord(alu_res);
                    endcase
                end
            end
            ST_EV_MUL:
            begin
                mul_hi_reg <= mul_sum[WORD_BITS:1];
                mul_lo_reg <= {mul_sum[0], mul_lo_reg[WORD_BITS-1:1]};
            end
            ST_EV_DIV:
            begin
                div_rem_reg <= div_ge ? div_diff[WORD_BITS-1:0] : div_r2[WORD_BITS-1:0];
                div_q_reg   <= {div_q_reg[DIV_STEPS-2:0], div_ge};
                div_num_reg <= div_num_reg << 1;
            end
            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    out_data_reg <= {res_reg[2], res_reg[1], res_reg[0]};
                end
            end
            default:
            begin
            end
        endcase

        if (knot_store)
        begin
            case (kidx_reg)
                2'd0:    t01_reg <= knot_val;
                2'd1:    t12_reg <= knot_val;
                default: t23_reg <= knot_val;
            endcase
        end

        if (wr_en)
        begin
            case (uop.dst)
                R_S02:   s02_reg <= wr_val;
                R_S13:   s13_reg <= wr_val;
                R_D21:   d21_reg <= wr_val;
                R_M01:   m01_reg <= wr_val;
                R_M23:   m23_reg <= wr_val;
                R_M02:   m02_reg <= wr_val;
                R_M13:   m13_reg <= wr_val;
                R_M1:    m1_reg  <= wr_val;
                R_M2:    m2_reg  <= wr_val;
                R_A:     a_reg   <= wr_val;
                R_B:     b_reg   <= wr_val;
                R_R:     r_reg   <= wr_val;
                default: x_reg   <= wr_val;
            endcase
        end
    end

    // checks
    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside the done state");

    a_load_shift: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && !s_tuser) |=> (win_reg[WIN_DEPTH-3] == $past(s_tdata[COORD_BITS-1:0])))
        else $error("loaded point not at the window head");

    a_seq_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EV_ISSUE || state_reg == ST_EV_WB)
            |-> (axis_reg != 2'd3 && step_reg <= LAST_STEP))
        else $error("sequence counters out of range");

    a_mant_norm: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_K_SHIFT || state_reg == ST_K_EXP) |-> mant_reg[MANT_BITS-1])
        else $error("knot mantissa lost its leading one");

endmodule
`default_nettype wire

// ===== bench/centripetal_catmull_rom_eval_unit_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// centripetal_catmull_rom_eval_unit_checker
// Watches the config, request and result channels, keeps its own copy of the
// control point window and alpha, predicts each curve point and compares it.
// ----------------------------------------------------------------------------
module centripetal_catmull_rom_eval_unit_checker (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_valid,
    input  wire logic                                cfg_ready,
    input  wire logic [ccre_pkg::ALPHA_BITS-1:0]     cfg_data,
    input  wire logic                                s_tvalid,
    input  wire logic                                s_tready,
    input  wire logic [ccre_pkg::IN_TDATA_W-1:0]     s_tdata,
    input  wire logic                                s_tuser,
    input  wire logic                                m_tvalid,
    input  wire logic                                m_tready,
    input  wire logic [ccre_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output int                                       fail_count,
    output int                                       pending_count,
    output int                                       result_count
);
    import ccre_pkg::*;

    typedef logic signed [63:0] w64_t;
    typedef struct {
        coord_t x;
        coord_t y;
        coord_t z;
    } curve_point_t;

    w64_t                  window [12];
    logic [ALPHA_BITS-1:0] alpha_reg;
    curve_point_t          curve_queue [$];

    assign pending_count = curve_queue.size();

    task automatic report(input string msg);
        $display("mismatch: %s", msg);
        fail_count++;
    endtask

    function automatic w64_t add_sat(w64_t a, w64_t b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63])
        begin
            return s[64] ? WORD_MIN : WORD_MAX;
        end
        return s[63:0];
    endfunction

    function automatic w64_t sub_sat(w64_t a, w64_t b);
        logic signed [64:0] s;
        s = {a[63], a} - {b[63], b};
        if (s[64] != s[63])
        begin
            return s[64] ? WORD_MIN : WORD_MAX;
        end
        return s[63:0];
    endfunction

    function automatic logic [63:0] abs_of(w64_t a);
        return a[63] ? (~a + 64'd1) : a;
    endfunction

    function automatic w64_t clamp_wide(logic neg, logic [127:0] q);
        if (q > 128'h7FFF_FFFF_FFFF_FFFF)
        begin
            return neg ? WORD_MIN : WORD_MAX;
        end
        return neg ? -w64_t'(q[63:0]) : w64_t'(q[63:0]);
    endfunction

    function automatic w64_t fx_mul(w64_t a, w64_t b);
        logic [127:0] p;
        p = {64'd0, abs_of(a)} * {64'd0, abs_of(b)};
        return clamp_wide(a[63] ^ b[63], p >> 16);
    endfunction

    function automatic w64_t fx_div(w64_t a, w64_t b);
        logic [127:0] n;
        n = {64'd0, abs_of(a)} << 16;
        return clamp_wide(a[63], n / {64'd0, b});
    endfunction

    function automatic int msb_count(logic [63:0] v);
        int n;
        n = 0;
        while (v != 0)
        begin
            n++;
            v = v >> 1;
        end
        return n;
    endfunction

    function automatic logic [63:0] log2_fraction(logic [63:0] m);
        logic [63:0] f;
        f = 0;
        for (int i = 0; i < LOG_BITS; i++)
        begin
            m = (m * m) >> 30;
            f = f << 1;
            if (m >= (64'd1 << 31))
            begin
                f = f | 64'd1;
                m = m >> 1;
            end
        end
        return f;
    endfunction

    function automatic logic [63:0] exp2_mantissa(logic [63:0] frac);
        logic [63:0] m;
        logic [63:0] c;
        m = 64'd1 << 30;
        for (int b = 29; b >= 0; b--)
        begin
            c = m | (64'd1 << b);
            if (log2_fraction(c) <= frac)
            begin
                m = c;
            end
        end
        return m;
    endfunction

    // knot spacing |pb - pa| ^ alpha in Q.16
    function automatic w64_t knot_spacing(int ia, int ib);
        logic [63:0] mags [3];
        logic [63:0] mx;
        logic [63:0] sum;
        logic [63:0] v;
        logic [63:0] mant;
        int          s;
        int          p;
        w64_t        lg;
        w64_t        e;
        w64_t        e_int;
        w64_t        sh;
        mx  = 0;
        sum = 0;
        for (int j = 0; j < 3; j++)
        begin
            mags[j] = abs_of(sub_sat(window[ib + j], window[ia + j]));
            if (mags[j] > mx)
            begin
                mx = mags[j];
            end
        end
        s = msb_count(mx) > 31 ? msb_count(mx) - 31 : 0;
        for (int j = 0; j < 3; j++)
        begin
            v   = mags[j] >> s;
            sum = sum + v * v;
        end
        if (sum == 0)
        begin
            return (alpha_reg == 0) ? ONE_Q16 : 0;
        end
        p    = msb_count(sum) - 1;
        mant = (p >= 30) ? (sum >> (p - 30)) : (sum << (30 - p));
        lg   = w64_t'((64'(p + 2 * s) << LOG_BITS) + log2_fraction(mant));
        lg   = lg - (w64_t'(32) << LOG_BITS);
        e     = (w64_t'({47'd0, alpha_reg}) * lg) >>> 17;
        e_int = e >>> LOG_BITS;
        mant  = exp2_mantissa(64'(e) & 64'hFF_FFFF);
        sh    = e_int - 14;
        if (sh > 32)
        begin
            return WORD_MAX;
        end
        if (sh >= 0)
        begin
            return w64_t'(mant << sh);
        end
        if (sh <= -63)
        begin
            return 0;
        end
        return w64_t'(mant >> (-sh));
    endfunction

    function automatic curve_point_t curve_at(logic [T_BITS-1:0] t_raw);
        curve_point_t cp;
        w64_t t, t01, t12, t23, s02, s13;
        w64_t p0, p1, p2, p3, d21, m01, m23, m02, m13, m1, m2, a, b, r;
        t   = w64_t'({47'd0, t_raw});
        t01 = knot_spacing(0, 3);
        t12 = knot_spacing(3, 6);
        t23 = knot_spacing(6, 9);
        s02 = add_sat(t01, t12);
        s13 = add_sat(t12, t23);
        for (int j = 0; j < 3; j++)
        begin
            p0  = window[j];
            p1  = window[3 + j];
            p2  = window[6 + j];
            p3  = window[9 + j];
            d21 = sub_sat(p2, p1);
            m01 = (t01 > 1) ? fx_div(sub_sat(p1, p0), t01) : 0;
            m23 = (t23 > 1) ? fx_div(sub_sat(p3, p2), t23) : 0;
            m02 = (s02 > 1) ? fx_div(sub_sat(p2, p0), s02) : 0;
            m13 = (s13 > 1) ? fx_div(sub_sat(p3, p1), s13) : 0;
            m1  = add_sat(d21, fx_mul(t12, sub_sat(m01, m02)));
            m2  = add_sat(d21, fx_mul(t12, sub_sat(m23, m13)));
            a   = sub_sat(sub_sat(add_sat(m1, m2), d21), d21);
            b   = add_sat(add_sat(d21, d21), d21);
            b   = sub_sat(sub_sat(sub_sat(b, m1), m1), m2);
            r   = add_sat(fx_mul(a, t), b);
            r   = add_sat(fx_mul(r, t), m1);
            r   = add_sat(fx_mul(r, t), p1);
            case (j)
                0:       cp.x = to_coord(r);
                1:       cp.y = to_coord(r);
                default: cp.z = to_coord(r);
            endcase
        end
        return cp;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        curve_point_t exp_pt;
        coord_t       got_x, got_y, got_z;
        if (!rst_n)
        begin
            for (int i = 0; i < 12; i++)
            begin
                window[i] = 0;
            end
            alpha_reg = ALPHA_RESET;
            curve_queue.delete();
            result_count = 0;
            fail_count   = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                alpha_reg = cfg_data;
            end
            if (s_tvalid && s_tready)
            begin
                if (!s_tuser)
                begin
                    for (int i = 0; i < 9; i++)
                    begin
                        window[i] = window[i + 3];
                    end
                    window[9]  = extend(s_tdata[COORD_BITS-1:0]);
                    window[10] = extend(s_tdata[2*COORD_BITS-1:COORD_BITS]);
                    window[11] = extend(s_tdata[3*COORD_BITS-1:2*COORD_BITS]);
                end
                else
                begin
                    curve_queue.push_back(
                        curve_at(s_tdata[3*COORD_BITS +: T_BITS]));
                end
            end
            if (m_tvalid && m_tready)
            begin
                result_count++;
                got_x = m_tdata[COORD_BITS-1:0];
                got_y = m_tdata[2*COORD_BITS-1:COORD_BITS];
                got_z = m_tdata[3*COORD_BITS-1:2*COORD_BITS];
                if (curve_queue.size() == 0)
                begin
                    report($sformatf("result %0d with no request waiting", result_count));
                end
                else
                begin
                    exp_pt = curve_queue.pop_front();
                    if (got_x !== exp_pt.x)
                    begin
                        report($sformatf("result %0d curve_x got %h want %h",
                                         result_count, got_x, exp_pt.x));
                    end
                    if (got_y !== exp_pt.y)
                    begin
                        report($sformatf("result %0d curve_y got %h want %h",
                                         result_count, got_y, exp_pt.y));
                    end
                    if (got_z !== exp_pt.z)
                    begin
                        report($sformatf("result %0d curve_z got %h want %h",
                                         result_count, got_z, exp_pt.z));
                    end
                end
            end
        end
    end

endmodule

// ===== bench/centripetal_catmull_rom_eval_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// centripetal_catmull_rom_eval_unit_tb
// Drives load and evaluate requests and alpha writes into the segment
// evaluator under random idling and back pressure; the checker judges.
// ----------------------------------------------------------------------------
module centripetal_catmull_rom_eval_unit_tb;
    import ccre_pkg::*;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_EVAL = 1'b1;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [ALPHA_BITS-1:0]        cfg_data = '0;
    logic                         s_tvalid = 1'b0;
    logic                         s_tready;
    logic [IN_TDATA_W-1:0]        s_tdata = '0;
    logic                         s_tuser = 1'b0;
    logic                         m_tvalid;
    logic                         m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]       m_tdata;
    int                           fail_count;
    int                           pending_count;
    int                           result_count;

    int                           send_idle = 0;
    int                           recv_idle = 0;
    int                           hold_cycles = 0;
    int                           item_count = 0;
    int                           alpha_writes = 0;
    coord_t                       last_pt [3];

    always #2 clk = ~clk;

    centripetal_catmull_rom_eval_unit dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    centripetal_catmull_rom_eval_unit_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .fail_count(fail_count), .pending_count(pending_count),
        .result_count(result_count)
    );

    // receiver with random stalls and an optional long hold
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            m_tready    <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    initial
    begin
        #(100_000_000);
        $display("[centripetal_catmull_rom_eval_unit] ERROR");
        $finish;
    end

    task automatic send_request(input logic req, input coord_t x, input coord_t y,
                                input coord_t z, input logic [T_BITS-1:0] t);
        if ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle)
            begin
                @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {7'd0, t, z, y, x};
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        item_count++;
        if (req == REQ_LOAD)
        begin
            last_pt[0] = x;
            last_pt[1] = y;
            last_pt[2] = z;
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
    endtask

    task automatic write_alpha(input logic [ALPHA_BITS-1:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        alpha_writes++;
    endtask

    function automatic coord_t pick_coord(int axis);
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(9))
            0, 1, 2: return coord_t'($signed(r[23:0]));
            3, 4:    return coord_t'($signed(r[35:0]));
            5:       return r[COORD_BITS-1:0];
            6:       return $urandom_range(1) ? {1'b0, {(COORD_BITS-1){1'b1}}}
                                             : {1'b1, {(COORD_BITS-1){1'b0}}};
            7:       return last_pt[axis];
            8:       return last_pt[axis] + coord_t'($signed(r[1:0]));
            default: return coord_t'($signed(r[15:0]));
        endcase
    endfunction

    function automatic logic [T_BITS-1:0] pick_t();
        if ($urandom_range(9) == 0)
        begin
            return T_BITS'($urandom);
        end
        return T_BITS'($urandom_range(65536));
    endfunction

    task automatic load_random();
        coord_t x, y, z;
        x = pick_coord(0);
        y = pick_coord(1);
        z = pick_coord(2);
        send_request(REQ_LOAD, x, y, z, T_BITS'($urandom));
    endtask

    task automatic eval_random();
        send_request(REQ_EVAL, coord_t'({$urandom, $urandom}), coord_t'({$urandom, $urandom}),
                     coord_t'({$urandom, $urandom}), pick_t());
    endtask

    task automatic random_phase(input int items);
        int target;
        target = item_count + items;
        while (item_count < target)
        begin
            if ($urandom_range(9) < 8)
            begin
                repeat ($urandom_range(4, 1)) load_random();
                repeat ($urandom_range(3, 1)) eval_random();
            end
            else if ($urandom_range(1) == 0)
            begin
                load_random();
            end
            else
            begin
                eval_random();
            end
        end
    endtask

    localparam coord_t C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam coord_t C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    initial
    begin
        logic [ALPHA_BITS-1:0] alpha_plan [7];
        alpha_plan = '{17'd0, 17'd65536, 17'd1, 17'd16384, 17'd49152, 17'd32768, 17'd0};
        last_pt = '{0, 0, 0};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // short history and coincident zero points
        send_request(REQ_EVAL, 0, 0, 0, 17'd32768);
        send_request(REQ_LOAD, 48'sd65536, 48'sd131072, -48'sd65536, 0);
        send_request(REQ_EVAL, 0, 0, 0, 17'd65536);
        // one-lsb spacing
        send_request(REQ_LOAD, 48'sd65537, 48'sd131072, -48'sd65536, 0);
        send_request(REQ_LOAD, 48'sd65537, 48'sd131073, -48'sd65536, 0);
        send_request(REQ_EVAL, 0, 0, 0, 17'd1);
        // extremes, saturation, out-of-range t
        send_request(REQ_LOAD, C_MAX, C_MIN, C_MAX, 17'h1FFFF);
        send_request(REQ_LOAD, C_MIN, C_MAX, C_MIN, 0);
        send_request(REQ_EVAL, C_MAX, C_MAX, C_MAX, 17'd0);
        send_request(REQ_EVAL, C_MIN, C_MIN, C_MIN, 17'h1FFFF);
        send_request(REQ_LOAD, -48'sd1, 48'sd1, 48'sd0, 0);
        send_request(REQ_EVAL, -48'sd1, -48'sd1, -48'sd1, 17'd65536);
        send_request(REQ_EVAL, 0, 0, 0, 17'd40000);

        // alpha 0 with coincident points
        write_alpha(17'd0);
        send_request(REQ_LOAD, 48'sd100, 48'sd100, 48'sd100, 0);
        send_request(REQ_LOAD, 48'sd100, 48'sd100, 48'sd100, 0);
        send_request(REQ_EVAL, 0, 0, 0, 17'd30000);
        write_alpha(17'd32768);

        // long output hold while the sender keeps offering requests
        hold_cycles = 12000;
        repeat (4) load_random();
        repeat (3) eval_random();
        drain_results();

        for (int ph = 0; ph < 7; ph++)
        begin
            if (ph < 2)
            begin
                send_idle = 29;
                recv_idle = 51;
            end
            else if (ph < 4)
            begin
                send_idle = 51;
                recv_idle = 29;
            end
            else
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            write_alpha(ph == 6 ? ALPHA_BITS'($urandom_range(65536)) : alpha_plan[ph]);
            random_phase(245);
        end

        drain_results();
        $display("covered %0d requests, %0d curve points, %0d alpha writes",
                 item_count, result_count, alpha_writes);
        $display("alpha 0 to 1.0, t 0 to full 17 bits, extreme and coincident points");
        if (fail_count == 0)
        begin
            $display("[centripetal_catmull_rom_eval_unit] OK");
        end
        else
        begin
            $display("[centripetal_catmull_rom_eval_unit] ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/ccre_pkg.sv
hw/rtl/centripetal_catmull_rom_eval_unit.sv
bench/centripetal_catmull_rom_eval_unit_checker.sv
bench/centripetal_catmull_rom_eval_unit_tb.sv
